>>> design/qbot_pkg.sv
// ----------------------------------------------------------------------------
// qbot_pkg
// Shared constants for the quad versus box overlap test.
// ----------------------------------------------------------------------------
package qbot_pkg;

  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned NumCorners   = 4;
  localparam int unsigned NumInFields  = 12;
  localparam int unsigned OutDataBits  = 8;

endpackage

>>> design/quad_box_overlap_test.sv
// ----------------------------------------------------------------------------
// quad_box_overlap_test
// Separating-axis overlap test between a quadrilateral and an axis-aligned box.
// ----------------------------------------------------------------------------
// Channel  | Direction | Transaction contents
// s_axis   | in        | quad corners 0..3 (x, y), box min x, min y, max x, max y
// m_axis   | out       | overlaps flag (1 = overlap or touch)
//
// Five register stages: input, edge deltas and extent test, products,
// projections, result. One transaction per cycle unless m_axis stalls.
// The rate is set by one multiplier per product term, all working in parallel.
// Each stage advances when the stage after it is empty or moving, so bubbles
// are squeezed out under output stalls. Reset clears all valid bits.
// ----------------------------------------------------------------------------
module quad_box_overlap_test #(
  parameter int unsigned CoordBits = qbot_pkg::CoordBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // quad_x0, quad_y0, quad_x1, quad_y1, quad_x2, quad_y2, quad_x3, quad_y3,
  // box_min_x, box_min_y, box_max_x, box_max_y
  input  logic [((qbot_pkg::NumInFields*CoordBits+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // overlaps
  output logic [qbot_pkg::OutDataBits-1:0] m_axis_tdata
);

  import qbot_pkg::*;

  localparam int unsigned CW = CoordBits;
  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned PW = 2 * CoordBits + 1;
  localparam int unsigned JW = 2 * CoordBits + 2;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] delta_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [JW-1:0] proj_t;

  logic rdy0, rdy1, rdy2, rdy3, rdy4;
  logic v0_q, v1_q, v2_q, v3_q, v4_q;

  // stage 0: input register
  coord_t qx0_q [NumCorners];
  coord_t qy0_q [NumCorners];
  coord_t bx0_q, by0_q, bx1_q, by1_q;

  // stage 1: deltas and extent test
  coord_t qx1_q [NumCorners];
  coord_t qy1_q [NumCorners];
  coord_t bx1a_q, by1a_q, bx1b_q, by1b_q;
  delta_t dx_q [NumCorners];
  delta_t dy_q [NumCorners];
  logic   axis1_q;
  delta_t dx_d [NumCorners];
  delta_t dy_d [NumCorners];
  logic   axis_d;

  // stage 2: products
  prod_t pqy_q [NumCorners][NumCorners];
  prod_t pqx_q [NumCorners][NumCorners];
  prod_t pby0_q [NumCorners];
  prod_t pby1_q [NumCorners];
  prod_t pbx0_q [NumCorners];
  prod_t pbx1_q [NumCorners];
  logic  axis2_q;

  // stage 3: projections
  proj_t prq_q [NumCorners][NumCorners];
  proj_t prb_q [NumCorners][NumCorners];
  logic  axis3_q;

  // stage 4: result
  logic  ovl_q;
  logic  ovl_d;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign s_axis_tready = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= s_axis_tvalid;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && s_axis_tvalid) begin
      for (int k = 0; k < NumCorners; k++) begin
        qx0_q[k] <= s_axis_tdata[(2*k)*CW +: CW];
        qy0_q[k] <= s_axis_tdata[(2*k+1)*CW +: CW];
      end
      bx0_q <= s_axis_tdata[8*CW +: CW];
      by0_q <= s_axis_tdata[9*CW +: CW];
      bx1_q <= s_axis_tdata[10*CW +: CW];
      by1_q <= s_axis_tdata[11*CW +: CW];
    end
  end

  always_comb begin
    coord_t mnx, mxx, mny, mxy;
    mnx = qx0_q[0];
    mxx = qx0_q[0];
    mny = qy0_q[0];
    mxy = qy0_q[0];
    for (int k = 1; k < NumCorners; k++) begin
      if (qx0_q[k] < mnx) mnx = qx0_q[k];
      if (qx0_q[k] > mxx) mxx = qx0_q[k];
      if (qy0_q[k] < mny) mny = qy0_q[k];
      if (qy0_q[k] > mxy) mxy = qy0_q[k];
    end
    axis_d = !(mxx < bx0_q || mnx > bx1_q || mxy < by0_q || mny > by1_q);
    for (int e = 0; e < NumCorners; e++) begin
      dx_d[e] = DW'(qx0_q[(e+1)%NumCorners]) - DW'(qx0_q[e]);
      dy_d[e] = DW'(qy0_q[(e+1)%NumCorners]) - DW'(qy0_q[e]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && v0_q) begin
      qx1_q   <= qx0_q;
      qy1_q   <= qy0_q;
      bx1a_q  <= bx0_q;
      by1a_q  <= by0_q;
      bx1b_q  <= bx1_q;
      by1b_q  <= by1_q;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      axis1_q <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      for (int e = 0; e < NumCorners; e++) begin
        for (int k = 0; k < NumCorners; k++) begin
          pqy_q[e][k] <= PW'(qy1_q[k]) * PW'(dx_q[e]);
          pqx_q[e][k] <= PW'(qx1_q[k]) * PW'(dy_q[e]);
        end
        pby0_q[e] <= PW'(by1a_q) * PW'(dx_q[e]);
        pby1_q[e] <= PW'(by1b_q) * PW'(dx_q[e]);
        pbx0_q[e] <= PW'(bx1a_q) * PW'(dy_q[e]);
        pbx1_q[e] <= PW'(bx1b_q) * PW'(dy_q[e]);
      end
      axis2_q <= axis1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      for (int e = 0; e < NumCorners; e++) begin
        for (int k = 0; k < NumCorners; k++) begin
          prq_q[e][k] <= JW'(pqy_q[e][k]) - JW'(pqx_q[e][k]);
        end
        prb_q[e][0] <= JW'(pby0_q[e]) - JW'(pbx0_q[e]);
        prb_q[e][1] <= JW'(pby0_q[e]) - JW'(pbx1_q[e]);
        prb_q[e][2] <= JW'(pby1_q[e]) - JW'(pbx1_q[e]);
        prb_q[e][3] <= JW'(pby1_q[e]) - JW'(pbx0_q[e]);
      end
      axis3_q <= axis2_q;
    end
  end

  always_comb begin
    proj_t qlo, qhi, blo, bhi;
    ovl_d = axis3_q;
    for (int e = 0; e < NumCorners; e++) begin
      qlo = prq_q[e][0];
      qhi = prq_q[e][0];
      blo = prb_q[e][0];
      bhi = prb_q[e][0];
      for (int k = 1; k < NumCorners; k++) begin
        if (prq_q[e][k] < qlo) qlo = prq_q[e][k];
        if (prq_q[e][k] > qhi) qhi = prq_q[e][k];
        if (prb_q[e][k] < blo) blo = prb_q[e][k];
        if (prb_q[e][k] > bhi) bhi = prb_q[e][k];
      end
      if (qhi < blo || bhi < qlo) ovl_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      ovl_q <= ovl_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {{(OutDataBits-1){1'b0}}, ovl_q};

endmodule

>>> tb/sv/tb_quad_box_overlap_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quad_box_overlap_test
// Self-checking bench for the quad versus box separating-axis overlap test.
// Directed cases cover touching and separated extents, separation along a
// quad edge, degenerate edges, inverted boxes and full-range coordinates.
// Random queries follow under several idle/stall mixes and three drain pauses.
// Every accepted query is predicted with exact 64-bit integer projections
// and checked in order against the overlaps flag of each output transaction.
// ----------------------------------------------------------------------------
module tb_quad_box_overlap_test;
  import qbot_pkg::*;

  localparam int CoordBits  = CoordBitsDef;
  localparam int InBits     = ((NumInFields * CoordBits + 7) / 8) * 8;
  localparam int CycleLimit = 200000;

  typedef logic signed [CoordBits-1:0] coord_t;

  // quad_x0 sits in the lowest bits
  typedef struct packed {
    coord_t box_max_y;
    coord_t box_max_x;
    coord_t box_min_y;
    coord_t box_min_x;
    coord_t y3;
    coord_t x3;
    coord_t y2;
    coord_t x2;
    coord_t y1;
    coord_t x1;
    coord_t y0;
    coord_t x0;
  } quad_box_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // quad_x0, quad_y0, quad_x1, quad_y1, quad_x2, quad_y2, quad_x3, quad_y3,
  // box_min_x, box_min_y, box_max_x, box_max_y
  logic [InBits-1:0]      s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // overlaps
  logic [OutDataBits-1:0] m_axis_tdata;

  bit expected_overlaps[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  quad_box_overlap_test #(
    .CoordBits(CoordBits)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_overlaps.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time,
                 m_axis_tdata[0]);
        mismatch_count++;
      end else if (m_axis_tdata[0] !== expected_overlaps[0]) begin
        $display("%0t: overlaps mismatch, expected %0d, actual %0d", $time,
                 expected_overlaps[0], m_axis_tdata[0]);
        mismatch_count++;
        void'(expected_overlaps.pop_front());
      end else begin
        void'(expected_overlaps.pop_front());
      end
    end
  end

  function automatic quad_box_t make_query(input int x0, input int y0, input int x1,
                                           input int y1, input int x2, input int y2,
                                           input int x3, input int y3, input int bx0,
                                           input int by0, input int bx1, input int by1);
    quad_box_t q;
    q.x0 = coord_t'(x0);
    q.y0 = coord_t'(y0);
    q.x1 = coord_t'(x1);
    q.y1 = coord_t'(y1);
    q.x2 = coord_t'(x2);
    q.y2 = coord_t'(y2);
    q.x3 = coord_t'(x3);
    q.y3 = coord_t'(y3);
    q.box_min_x = coord_t'(bx0);
    q.box_min_y = coord_t'(by0);
    q.box_max_x = coord_t'(bx1);
    q.box_max_y = coord_t'(by1);
    return q;
  endfunction

  // Separating-axis test with unnormalized edge normals, exact in 64 bits
  function automatic bit predict_overlap(input quad_box_t q);
    longint qx[4], qy[4], bx[4], by[4];
    longint minx, maxx, miny, maxy, dx, dy, p, qlo, qhi, blo, bhi;
    int     j;
    qx[0] = longint'($signed(q.x0));
    qy[0] = longint'($signed(q.y0));
    qx[1] = longint'($signed(q.x1));
    qy[1] = longint'($signed(q.y1));
    qx[2] = longint'($signed(q.x2));
    qy[2] = longint'($signed(q.y2));
    qx[3] = longint'($signed(q.x3));
    qy[3] = longint'($signed(q.y3));
    bx[0] = longint'($signed(q.box_min_x));
    by[0] = longint'($signed(q.box_min_y));
    bx[1] = longint'($signed(q.box_max_x));
    by[1] = by[0];
    bx[2] = bx[1];
    by[2] = longint'($signed(q.box_max_y));
    bx[3] = bx[0];
    by[3] = by[2];
    minx = qx[0];
    maxx = qx[0];
    miny = qy[0];
    maxy = qy[0];
    for (int i = 1; i < 4; i++) begin
      if (qx[i] < minx) minx = qx[i];
      if (qx[i] > maxx) maxx = qx[i];
      if (qy[i] < miny) miny = qy[i];
      if (qy[i] > maxy) maxy = qy[i];
    end
    if (maxx < bx[0] || minx > bx[1] || maxy < by[0] || miny > by[2]) return 1'b0;
    for (int i = 0; i < 4; i++) begin
      j  = (i + 1) % 4;
      dx = qx[j] - qx[i];
      dy = qy[j] - qy[i];
      for (int k = 0; k < 4; k++) begin
        p = qy[k] * dx - qx[k] * dy;
        if (k == 0 || p < qlo) qlo = p;
        if (k == 0 || p > qhi) qhi = p;
        p = by[k] * dx - bx[k] * dy;
        if (k == 0 || p < blo) blo = p;
        if (k == 0 || p > bhi) bhi = p;
      end
      if (qhi < blo || bhi < qlo) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic quad_box_t random_query();
    int c[12];
    int kind, spread, cx, cy, a, b, k;
    kind = $urandom_range(9);
    if (kind == 0) begin
      for (int i = 0; i < 12; i++) c[i] = int'($urandom_range(65535)) - 32768;
    end else if (kind == 1) begin
      for (int i = 0; i < 12; i++) begin
        case ($urandom_range(5))
          0: c[i] = -32768;
          1: c[i] = -32767;
          2: c[i] = -1;
          3: c[i] = 0;
          4: c[i] = 1;
          default: c[i] = 32767;
        endcase
      end
    end else begin
      case ($urandom_range(3))
        0: spread = 3;
        1: spread = 40;
        2: spread = 900;
        default: spread = 20000;
      endcase
      cx = int'($urandom_range(65535)) - 32768;
      cy = int'($urandom_range(65535)) - 32768;
      for (int i = 0; i < 4; i++) begin
        c[2*i]   = cx + int'($urandom_range(2 * spread)) - spread;
        c[2*i+1] = cy + int'($urandom_range(2 * spread)) - spread;
      end
      for (int i = 0; i < 2; i++) begin
        a = (i == 0 ? cx : cy) + int'($urandom_range(2 * spread)) - spread;
        b = (i == 0 ? cx : cy) + int'($urandom_range(2 * spread)) - spread;
        // keep min below max most of the time, leave some boxes inverted
        if ((a > b) != ($urandom_range(9) == 0)) begin
          c[8+i]  = b;
          c[10+i] = a;
        end else begin
          c[8+i]  = a;
          c[10+i] = b;
        end
      end
    end
    if ($urandom_range(7) == 0) begin
      k = $urandom_range(3);
      c[2*((k+1)%4)]   = c[2*k];
      c[2*((k+1)%4)+1] = c[2*k+1];
    end
    for (int i = 0; i < 12; i++) begin
      if (c[i] > 32767) c[i] = 32767;
      if (c[i] < -32768) c[i] = -32768;
    end
    return make_query(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7],
                      c[8], c[9], c[10], c[11]);
  endfunction

  task automatic send_query(input quad_box_t q);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= q;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_overlaps.push_back(predict_overlap(q));
  endtask

  task automatic test_directed_cases();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_query(make_query(0, 0, 10, 0, 10, 10, 0, 10, 0, 0, 10, 10));
    send_query(make_query(10, 0, 20, 0, 20, 10, 10, 10, 0, 0, 10, 10));
    send_query(make_query(11, 0, 20, 0, 20, 10, 11, 10, 0, 0, 10, 10));
    send_query(make_query(0, 10, 10, 10, 10, 20, 0, 20, 0, 0, 10, 10));
    send_query(make_query(0, 11, 10, 11, 10, 20, 0, 20, 0, 0, 10, 10));
    send_query(make_query(-20, 0, -11, 0, -11, 10, -20, 10, -10, 0, 10, 10));
    // edge axis separates although extents overlap
    send_query(make_query(8, 17, 17, 8, 20, 11, 11, 20, 0, 0, 10, 10));
    // edge axis touches the box corner
    send_query(make_query(5, 15, 15, 5, 18, 8, 8, 18, 0, 0, 10, 10));
    // all corners on one point, inside then outside
    send_query(make_query(5, 5, 5, 5, 5, 5, 5, 5, 0, 0, 10, 10));
    send_query(make_query(15, 5, 15, 5, 15, 5, 15, 5, 0, 0, 10, 10));
    // degenerate edge with coincident corners
    send_query(make_query(8, 17, 8, 17, 20, 11, 11, 20, 0, 0, 10, 10));
    // inverted boxes
    send_query(make_query(0, 0, 10, 0, 10, 10, 0, 10, 10, 10, 0, 0));
    send_query(make_query(3, 3, 6, 3, 6, 6, 3, 6, 8, 0, 2, 10));
    send_query(make_query(0, 0, 10, 0, 10, 10, 0, 10, 0, 10, 10, 5));
    // full-range coordinates
    send_query(make_query(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
                          -32768, -32768, 32767, 32767));
    send_query(make_query(-32768, 32767, 32767, -32768, 32767, -32767, -32767, 32767,
                          30000, 30000, 32767, 32767));
    send_query(make_query(-32768, 32767, 32767, -32768, 32767, 32767, -32767, 32767,
                          32767, -32768, 32767, -32768));
    send_query(make_query(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, -32768, -32768));
    send_query(make_query(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767, 32767));
    send_query(make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // self-crossing quad
    send_query(make_query(0, 0, 20, 20, 20, 0, 0, 20, 9, 12, 11, 14));
    send_query(make_query(0, 0, 20, 20, 20, 0, 0, 20, -5, 3, -1, 6));
  endtask

  task automatic test_random_queries(input int count, input int idle_pct, input int stall_pct);
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    repeat (count) send_query(random_query());
  endtask

  task automatic test_drain_pause();
    src_idle_pct  = 20;
    snk_stall_pct = 50;
    repeat (3) begin
      repeat (20) send_query(random_query());
      s_axis_tvalid <= 1'b0;
      while (expected_overlaps.size() != 0) @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_queries(300, 0, 0);
    test_random_queries(300, 53, 0);
    test_random_queries(300, 0, 53);
    test_random_queries(300, 36, 36);
    test_drain_pause();
    while (expected_overlaps.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (mismatch_count == 0 && expected_overlaps.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> quad_box_overlap_test.f
design/qbot_pkg.sv
design/quad_box_overlap_test.sv
tb/sv/tb_quad_box_overlap_test.sv
